// ===== rtl/assert_macros.svh =====
// assertion helpers for the pid controller rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold in the same cycle
`define PIDC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the antecedent
`define PIDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pidc_pkg.sv =====
// shared types, constants and helpers for the pid controller
// no dependencies
`default_nettype none

package pidc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LEEWAY    = 30;
  localparam int DW        = 32;
  // width of a product after the fraction shift
  localparam int PW        = 2 * DW - FRAC_BITS;
  // width for exact limit compares, leeway raw value stays below 2^34
  localparam int LW        = 36;
  localparam logic signed [LW-1:0] LEEWAY_RAW = LW'(longint'(LEEWAY) << FRAC_BITS);

  localparam int CW = 3;
  localparam logic [CW-1:0] CFG_TARGET     = 3'd0;
  localparam logic [CW-1:0] CFG_KP         = 3'd1;
  localparam logic [CW-1:0] CFG_KI_DT      = 3'd2;
  localparam logic [CW-1:0] CFG_KD_OVER_DT = 3'd3;
  localparam logic [CW-1:0] CFG_OUT_MIN    = 3'd4;
  localparam logic [CW-1:0] CFG_OUT_MAX    = 3'd5;
  localparam logic [CW-1:0] CFG_INTEG_MIN  = 3'd6;
  localparam logic [CW-1:0] CFG_INTEG_MAX  = 3'd7;

  typedef struct packed {
    logic signed [DW-1:0] target;
    logic signed [DW-1:0] kp;
    logic signed [DW-1:0] ki_dt;
    logic signed [DW-1:0] kd_over_dt;
    logic signed [DW-1:0] out_min;
    logic signed [DW-1:0] out_max;
    logic signed [DW-1:0] integ_min;
    logic signed [DW-1:0] integ_max;
  } cfg_t;

  // front stage payload
  typedef struct packed {
    logic                 restart;
    logic signed [DW-1:0] err;
    logic signed [DW-1:0] diff;
  } s1_t;

  // term stage payload
  typedef struct packed {
    logic signed [PW-1:0] p;
    logic signed [DW-1:0] integ;
    logic signed [PW-1:0] d;
  } s2_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7fff_ffff;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      return DW'(hi);
    end else if (v < lo) begin
      return DW'(lo);
    end
    return DW'(v);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pidc_regs.sv =====
// configuration register bank for the pid controller
// depends on pidc_pkg
`default_nettype none

module pidc_regs (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [2:0]             cfg_idx_i,
  input  wire logic [31:0]            cfg_data_i,
  output pidc_pkg::cfg_t              cfg_o
);
  import pidc_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARGET:     cfg_d.target     = cfg_data_i;
        CFG_KP:         cfg_d.kp         = cfg_data_i;
        CFG_KI_DT:      cfg_d.ki_dt      = cfg_data_i;
        CFG_KD_OVER_DT: cfg_d.kd_over_dt = cfg_data_i;
        CFG_OUT_MIN:    cfg_d.out_min    = cfg_data_i;
        CFG_OUT_MAX:    cfg_d.out_max    = cfg_data_i;
        CFG_INTEG_MIN:  cfg_d.integ_min  = cfg_data_i;
        CFG_INTEG_MAX:  cfg_d.integ_max  = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/pidc_front.sv =====
// input stage: error and measurement difference, keeps the previous sample
// depends on pidc_pkg
`default_nettype none

module pidc_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   accept_i,
  input  wire logic                   take_i,
  input  wire logic                   mode_i,
  input  wire logic signed [31:0]     sample_i,
  input  wire logic signed [31:0]     target_i,
  output logic                        s1_valid_o,
  output pidc_pkg::s1_t               s1_o
);
  import pidc_pkg::*;

  logic signed [DW-1:0] last_q;
  logic                 valid_q;
  s1_t                  s1_q;
  s1_t                  s1_d;

  always_comb begin
    s1_d.restart = mode_i;
    s1_d.err     = sat32(64'(target_i) - 64'(sample_i));
    s1_d.diff    = sat32(64'(last_q) - 64'(sample_i));
  end

  // previous sample follows every accepted beat, restart included
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        last_q  <= sample_i;
        valid_q <= 1'b1;
      end else if (take_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_o       = s1_q;

endmodule

`default_nettype wire

// ===== rtl/pidc_terms.sv =====
// term stage: three products and the clamped integrator
// depends on pidc_pkg
`default_nettype none

module pidc_terms (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   take_i,
  input  wire logic                   s2_take_i,
  input  wire pidc_pkg::s1_t          s1_i,
  input  wire pidc_pkg::cfg_t         cfg_i,
  output logic                        s2_valid_o,
  output pidc_pkg::s2_t               s2_o
);
  import pidc_pkg::*;

  logic signed [63:0]   prod_p;
  logic signed [63:0]   prod_i;
  logic signed [63:0]   prod_d;
  logic signed [PW:0]   isum;
  logic signed [DW-1:0] integ_q;
  logic signed [DW-1:0] integ_d;
  logic                 valid_q;
  s2_t                  s2_q;
  s2_t                  s2_d;

  assign prod_p = cfg_i.kp * s1_i.err;
  assign prod_i = cfg_i.ki_dt * s1_i.err;
  assign prod_d = cfg_i.kd_over_dt * s1_i.diff;

  assign isum = (PW+1)'(integ_q) + (PW+1)'(PW'(prod_i >>> FRAC_BITS));

  // lower limit is checked first: with inverted limits a sum below integ_min gives integ_min, any other gives integ_max
  always_comb begin
    if (isum < (PW+1)'(cfg_i.integ_min)) begin
      integ_d = cfg_i.integ_min;
    end else if (isum > (PW+1)'(cfg_i.integ_max)) begin
      integ_d = cfg_i.integ_max;
    end else begin
      integ_d = DW'(isum);
    end
  end

  always_comb begin
    s2_d.p     = PW'(prod_p >>> FRAC_BITS);
    s2_d.integ = integ_d;
    s2_d.d     = PW'(prod_d >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (take_i) begin
        integ_q <= s1_i.restart ? '0 : integ_d;
        valid_q <= !s1_i.restart;
      end else if (s2_take_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && !s1_i.restart) begin
      s2_q <= s2_d;
    end
  end

  assign s2_valid_o = valid_q;
  assign s2_o       = s2_q;

endmodule

`default_nettype wire

// ===== rtl/pidc_out.sv =====
// output stage: saturated sum, snapping near the limits, result register
// depends on pidc_pkg
`default_nettype none

module pidc_out (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire logic                   take_i,
  input  wire pidc_pkg::s2_t          s2_i,
  input  wire pidc_pkg::cfg_t         cfg_i,
  output logic                        out_valid_o,
  output logic signed [31:0]          drive_o,
  output logic                        clipped_high_o,
  output logic                        clipped_low_o
);
  import pidc_pkg::*;

  logic signed [DW-1:0] sum;
  logic signed [LW-1:0] sum_w;
  logic signed [LW-1:0] hi_lim;
  logic signed [LW-1:0] lo_lim;
  logic signed [DW-1:0] drive_d;
  logic                 hi_d;
  logic                 lo_d;
  logic                 valid_q;
  logic signed [DW-1:0] drive_q;
  logic                 hi_q;
  logic                 lo_q;

  assign sum    = sat32(64'(s2_i.p) + 64'(s2_i.integ) + 64'(s2_i.d));
  assign sum_w  = LW'(sum);
  assign hi_lim = LW'(cfg_i.out_max) - LEEWAY_RAW;
  assign lo_lim = LW'(cfg_i.out_min) + LEEWAY_RAW;

  // high side has priority, also with inverted limits
  always_comb begin
    drive_d = sum;
    hi_d    = 1'b0;
    lo_d    = 1'b0;
    if (sum_w > hi_lim) begin
      drive_d = cfg_i.out_max;
      hi_d    = 1'b1;
    end else if (sum_w < lo_lim) begin
      drive_d = cfg_i.out_min;
      lo_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        valid_q <= 1'b1;
      end else if (take_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      drive_q <= drive_d;
      hi_q    <= hi_d;
      lo_q    <= lo_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign drive_o        = drive_q;
  assign clipped_high_o = hi_q;
  assign clipped_low_o  = lo_q;

endmodule

`default_nettype wire

// ===== rtl/pid_controller_clamped_unit.sv =====
// pid controller top level, Q15.16 fixed point with clamped integrator
// a control beat passes the front, term and output registers in turn
// throughput: one beat per cycle through three register stages, each stage
//   moves on when the stage after it is empty or hands its beat on
// restart beats give no result; reset clears config, integrator, previous
//   sample and all valid flags
`default_nettype none
`include "assert_macros.svh"

module pid_controller_clamped_unit (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [2:0]             cfg_idx_i,
  input  wire logic [31:0]            cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   mode_i,
  input  wire logic signed [31:0]     sample_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [31:0]          drive_o,
  output logic                        clipped_high_o,
  output logic                        clipped_low_o
);
  import pidc_pkg::*;

  cfg_t cfg;
  s1_t  s1;
  s2_t  s2;
  logic s1_valid;
  logic s2_valid;
  logic out_free;
  logic s2_take;
  logic s2_free;
  logic s1_take;
  logic s1_free;
  logic accept;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign s2_take    = s2_valid && out_free;
  assign s2_free    = !s2_valid || out_free;
  assign s1_take    = s1_valid && s2_free;
  assign s1_free    = !s1_valid || s2_free;
  assign accept     = in_valid_i && s1_free;
  assign in_stall_o = !s1_free;

  pidc_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pidc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .take_i     (s1_take),
    .mode_i     (mode_i),
    .sample_i   (sample_i),
    .target_i   (cfg.target),
    .s1_valid_o (s1_valid),
    .s1_o       (s1)
  );

  pidc_terms u_terms (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (s1_take),
    .s2_take_i  (s2_take),
    .s1_i       (s1),
    .cfg_i      (cfg),
    .s2_valid_o (s2_valid),
    .s2_o       (s2)
  );

  pidc_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (s2_take),
    .take_i         (out_valid_o && !out_stall_i),
    .s2_i           (s2),
    .cfg_i          (cfg),
    .out_valid_o    (out_valid_o),
    .drive_o        (drive_o),
    .clipped_high_o (clipped_high_o),
    .clipped_low_o  (clipped_low_o)
  );

  `PIDC_ASSERT_SAME(a_clip_excl, out_valid_o, !(clipped_high_o && clipped_low_o), "both clip flags set")
  `PIDC_ASSERT_SAME(a_clip_high, out_valid_o && clipped_high_o, drive_o == cfg.out_max, "high snap value")
  `PIDC_ASSERT_SAME(a_stall_full, in_stall_o, out_valid_o && out_stall_i && s1_valid && s2_valid, "stall with room")
  `PIDC_ASSERT_NEXT(a_s2_load, s2_take, out_valid_o, "result lost")

endmodule

`default_nettype wire
